@@ design/sitoa_pkg.sv @@
package sitoa_pkg;

  localparam int BinW      = 32;
  localparam int NumDigits = 10;
  localparam int BcdW      = 4 * NumDigits;
  localparam int StepW     = $clog2(BinW);
  localparam int DigCntW   = $clog2(NumDigits + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input value, form magnitude, clear bcd
    logic conv_step;   // one shift-add-3 step
    logic shift_digit; // drop the top digit
    logic sel_minus;   // output character is the sign
  } sitoa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;
    logic top_zero;
  } sitoa_sts_t;

endpackage

@@ design/sitoa_dp.sv @@
module sitoa_dp
  import sitoa_pkg::*;
(
  input  logic            clk,
  input  logic [BinW-1:0] in_value,
  input  sitoa_cmd_t      cmd,
  output sitoa_sts_t      sts,
  output logic [7:0]      character
);

  logic [BinW-1:0] bin_r, bin_nxt;
  logic [BcdW-1:0] bcd_r, bcd_nxt;
  logic            neg_r, neg_nxt;
  logic [BcdW-1:0] bcd_adj;
  logic [3:0]      top_digit;

  assign top_digit = bcd_r[BcdW-1 -: 4];

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      neg_nxt = in_value[BinW-1];
      // unsigned negate, so the most negative value maps onto itself
      bin_nxt = in_value[BinW-1] ? (~in_value + {{(BinW-1){1'b0}}, 1'b1}) : in_value;
      bcd_nxt = '0;
    end else if (cmd.conv_step) begin
      {bcd_nxt, bin_nxt} = {bcd_adj[BcdW-2:0], bin_r, 1'b0};
    end else if (cmd.shift_digit) begin
      bcd_nxt = {bcd_r[BcdW-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign sts.neg      = neg_r;
  assign sts.top_zero = (top_digit == 4'd0);
  assign character    = cmd.sel_minus ? CHAR_MINUS : (CHAR_ZERO + {4'd0, top_digit});

endmodule

@@ design/sitoa_ctrl.sv @@
module sitoa_ctrl
  import sitoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic       out_tlast,
  output sitoa_cmd_t cmd,
  input  sitoa_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic [DigCntW-1:0] dig_r, dig_nxt;
  logic               last_dig;

  assign last_dig = (dig_r == DigCntW'(1));

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dig_nxt   = dig_r;
    cmd       = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    out_tlast  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = StepW'(BinW - 1);
          dig_nxt   = DigCntW'(NumDigits);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        step_nxt = step_r - StepW'(1);
        if (step_r == '0) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // strip leading zeros, keep at least one digit
        if (sts.top_zero && !last_dig) begin
          cmd.shift_digit = 1'b1;
          dig_nxt = dig_r - DigCntW'(1);
        end else begin
          state_nxt = sts.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        out_tvalid    = 1'b1;
        cmd.sel_minus = 1'b1;
        if (out_tready) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        out_tlast  = last_dig;
        if (out_tready) begin
          cmd.shift_digit = 1'b1;
          dig_nxt = dig_r - DigCntW'(1);
          if (last_dig) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      dig_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dig_r   <= dig_nxt;
    end
  end

endmodule

@@ design/signed_int_to_decimal_ascii_unit.sv @@
// signed 32-bit integer to decimal ascii text
//
// in_*  : one transaction carries one two's complement value in in_tdata.
// out_* : the text follows as a run of transactions, one character each,
//         most significant first; a leading '-' for negative values, no
//         leading zeros, zero gives a single '0'. out_tlast marks the final
//         character of the run.
//
// timing: after acceptance the value runs through 32 shift-add-3 steps of
// the binary to bcd datapath (one step a cycle), then leading zero digits
// are dropped at one a cycle (up to 9), then the 1 to 11 characters leave
// at one a cycle while the receiver does not stall. in_tready is high only
// while the block is idle, so one value is in work at a time.
//
// out_tvalid holds with stable data while out_tready is low; the run
// simply pauses. reset (rst_n low, synchronous) returns the controller to
// idle and drops any run in progress.
module signed_int_to_decimal_ascii_unit
  import sitoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] character
  output logic        out_tlast   // last_char
);

  sitoa_cmd_t cmd;
  sitoa_sts_t sts;

  sitoa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  sitoa_dp u_dp (
    .clk       (clk),
    .in_value  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .character (out_tdata)
  );

endmodule

@@ sim/tb.sv @@
module tb;
  import sitoa_pkg::CHAR_ZERO;
  import sitoa_pkg::CHAR_MINUS;

  localparam int MaxCycles = 400000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  class decimal_text_board;
    text_char_t expected_chars[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // spell out the decimal text the block owes for one accepted value
    function void note_value(logic [31:0] raw);
      logic [31:0] mag;
      logic [3:0]  digits [10];
      int          nd;
      mag = raw[31] ? (32'd0 - raw) : raw;
      nd = 0;
      do begin
        digits[nd] = 4'(mag % 32'd10);
        nd++;
        mag = mag / 32'd10;
      end while (mag != 0 && nd < 10);
      if (raw[31]) expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
      for (int i = nd - 1; i >= 0; i--)
        expected_chars.push_back('{code: CHAR_ZERO + 8'(digits[i]), last: (i == 0)});
    endfunction

    task check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected character 8'h%02h last=%0b", code, last));
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code)
        report($sformatf("character got 8'h%02h want 8'h%02h", code, want.code));
      if (last !== want.last)
        report($sformatf("tlast got %0b want %0b on 8'h%02h", last, want.last, want.code));
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  decimal_text_board board = new();

  int cycles = 0;
  int rx_tick = 0;
  int rx_mode = 0;
  int burst_left = 0;

  signed_int_to_decimal_ascii_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_value(in_tdata);
  end

  // receiver: stall pattern is redrawn at random from four modes
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_char(out_tdata, out_tlast);
    rx_tick++;
    if (rx_tick % 128 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_tick % 4 == 0);
      default: out_tready <= (rx_tick % 32) >= 8;
    endcase
  end

  task send_value(logic [31:0] v);
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
  endtask

  task hold_off(int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // bursts of random length, gaps of random length between them
  task pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) hold_off(0);
      else hold_off($urandom_range(1, 20));
    end
  endtask

  task drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function logic [31:0] pick_value();
    int          n;
    longint      lo;
    longint      hi;
    logic [31:0] mag;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        // random digit count, random sign
        n  = $urandom_range(1, 10);
        lo = (n == 1) ? 0 : 1;
        for (int i = 1; i < n; i++) lo = lo * 10;
        hi = (n == 1) ? 9 : lo * 10 - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        mag = $urandom_range(32'(hi), 32'(lo));
        return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
      end
      2: return 32'($signed($urandom_range(0, 199)) - 100);
      default:
        return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                    : 32'h7fff_ffff - $urandom_range(0, 3);
    endcase
  endfunction

  logic [31:0] directed_values [$] = '{
    32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
    -32'sd999999999, 32'd1234567890, -32'sd1234567890, 32'h5555_5555,
    32'haaaa_aaaa, -32'sd5, 32'd100000, -32'sd1000000000
  };

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      pace_sender();
    end
    drain_results();

    for (int k = 0; k < 300; k++) begin
      send_value(pick_value());
      if (k == 150) drain_results();
      else pace_sender();
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sitoa_pkg.sv
design/sitoa_dp.sv
design/sitoa_ctrl.sv
design/signed_int_to_decimal_ascii_unit.sv
sim/tb.sv
